/* hdl/rhrr_pkg.sv */
// Package for the rolling rescaled-range Hurst estimator.
// Holds the shared widths, output limits and state machine types.
// No dependencies.
`timescale 1ns / 1ps

package rhrr_pkg;

  localparam int DEF_MAX_WINDOW = 256;
  localparam int SAMPLE_W       = 32;
  localparam int CFG_W          = 9;
  localparam int HURST_W        = 16;
  localparam int FRAC_W         = 16;
  localparam int Q_FRAC         = 12;
  localparam int WINDOW_RESET   = 256;
  localparam int WINDOW_MIN     = 4;

  localparam logic [HURST_W-1:0] HURST_MAX = 16'h7fff;
  localparam logic [HURST_W-1:0] HURST_MIN = 16'h8000;

  typedef enum logic [1:0] {
    LOG_IDLE,
    LOG_NORM,
    LOG_SQR
  } log_state_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_WALK,
    BK_DRAIN,
    BK_LOGR,
    BK_LOGD,
    BK_LOGW,
    BK_DPREP,
    BK_DIV,
    BK_WRITE,
    BK_OUT
  } back_state_e;

endpackage

/* hdl/rhrr_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rhrr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/rhrr_log.sv */
// Iterative fixed-point log2 unit: normalize, then sixteen squaring steps.
// Depends on rhrr_pkg.
`timescale 1ns / 1ps

module rhrr_log import rhrr_pkg::*; #(
  parameter int IN_W = 91,
  localparam int PW  = $clog2(IN_W),
  localparam int LGW = PW + FRAC_W
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [IN_W-1:0] value_i,
  output logic            done_o,
  output logic [LGW-1:0]  log_o
);

  localparam logic [3:0] LastIter = 4'(FRAC_W - 1);

  log_state_e state_q, state_d;
  logic              done_q, done_d;
  logic [IN_W-1:0]   v_q;
  logic [PW-1:0]     sh_q;
  logic [PW-1:0]     p_q;
  logic [31:0]       m_q;
  logic [FRAC_W-1:0] frac_q;
  logic [3:0]        cnt_q;
  logic [LGW-1:0]    res_q;

  logic [63:0]       prod;
  logic [32:0]       sq_top;
  logic [FRAC_W-1:0] frac_nx;
  logic [31:0]       m_nx;

  assign prod    = 64'(m_q) * 64'(m_q);
  assign sq_top  = prod[63:31];
  assign frac_nx = {frac_q[FRAC_W-2:0], sq_top[32]};
  assign m_nx    = sq_top[32] ? sq_top[32:1] : sq_top[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LOG_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    unique case (state_q)
      LOG_IDLE: begin
        if (start_i) begin
          if (value_i == '0) begin
            done_d = 1'b1;
          end else begin
            state_d = LOG_NORM;
          end
        end
      end
      LOG_NORM: begin
        if (v_q[IN_W-1]) begin
          state_d = LOG_SQR;
        end
      end
      LOG_SQR: begin
        if (cnt_q == LastIter) begin
          state_d = LOG_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = LOG_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      LOG_IDLE: begin
        v_q   <= value_i;
        sh_q  <= '0;
        res_q <= '0;
      end
      LOG_NORM: begin
        if (v_q[IN_W-1]) begin
          m_q    <= v_q[IN_W-1 -: 32];
          p_q    <= PW'(IN_W - 1) - sh_q;
          cnt_q  <= '0;
          frac_q <= '0;
        end else if (v_q[IN_W-1 -: 8] == '0) begin
          v_q  <= v_q << 8;
          sh_q <= sh_q + PW'(8);
        end else begin
          v_q  <= v_q << 1;
          sh_q <= sh_q + PW'(1);
        end
      end
      LOG_SQR: begin
        m_q    <= m_nx;
        frac_q <= frac_nx;
        cnt_q  <= cnt_q + 4'd1;
        if (cnt_q == LastIter) begin
          res_q <= {p_q, frac_nx};
        end
      end
      default: begin
        v_q <= v_q;
      end
    endcase
  end

  assign done_o = done_q;
  assign log_o  = res_q;

endmodule

/* hdl/rhrr_front.sv */
// Front end: takes sample beats, tracks fill and write position, queues jobs.
// Depends on rhrr_pkg.
`timescale 1ns / 1ps

module rhrr_front import rhrr_pkg::*; #(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  localparam int AW = $clog2(MAX_WINDOW),
  localparam int WW = $clog2(MAX_WINDOW + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFG_W-1:0]    window_length_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SAMPLE_W-1:0] sample_value_i,
  output logic                restart_o,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output logic [SAMPLE_W-1:0] job_sample_o,
  output logic                job_full_o,
  output logic [AW-1:0]       job_base_o,
  output logic [AW-1:0]       job_wpos_o,
  output logic [WW-1:0]       job_window_o
);

  localparam int WinReset = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;
  localparam logic [AW+1:0] MaxExt  = (AW + 2)'(MAX_WINDOW);
  localparam logic [AW-1:0] LastPos = AW'(MAX_WINDOW - 1);

  logic [WW-1:0] win_q, win_d;
  logic [WW-1:0] fill_q;
  logic [AW-1:0] wpos_q;
  logic          full;
  logic [AW+1:0] base_sum;
  logic [AW-1:0] base;
  logic          accept;
  logic          pop;

  logic [SAMPLE_W-1:0] f_sample_q [2];
  logic                f_full_q   [2];
  logic [AW-1:0]       f_base_q   [2];
  logic [AW-1:0]       f_wpos_q   [2];
  logic [WW-1:0]       f_win_q    [2];
  logic                wr_ptr_q, rd_ptr_q;
  logic [1:0]          count_q;

  assign cfg_ready_o = 1'b1;
  assign restart_o   = cfg_valid_i;

  always_comb begin
    if (window_length_i < CFG_W'(WINDOW_MIN)) begin
      win_d = WW'(WINDOW_MIN);
    end else if (32'(window_length_i) > 32'(MAX_WINDOW)) begin
      win_d = WW'(MAX_WINDOW);
    end else begin
      win_d = WW'(window_length_i);
    end
  end

  assign full     = fill_q >= win_q;
  assign base_sum = (AW + 2)'(wpos_q) + MaxExt - (AW + 2)'(win_q);
  assign base     = (base_sum >= MaxExt) ? AW'(base_sum - MaxExt) : AW'(base_sum);

  assign in_ready_o = count_q != 2'd2;
  assign accept     = in_valid_i && in_ready_o;
  assign job_valid_o = count_q != 2'd0;
  assign pop        = job_valid_o && job_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= WW'(WinReset);
      fill_q   <= '0;
      wpos_q   <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        win_q  <= win_d;
        fill_q <= '0;
        wpos_q <= '0;
      end else if (accept) begin
        if (!full) begin
          fill_q <= fill_q + WW'(1);
        end
        wpos_q <= (wpos_q == LastPos) ? '0 : wpos_q + AW'(1);
      end
      if (accept) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, accept} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_sample_q[wr_ptr_q] <= sample_value_i;
      f_full_q[wr_ptr_q]   <= full;
      f_base_q[wr_ptr_q]   <= base;
      f_wpos_q[wr_ptr_q]   <= wpos_q;
      f_win_q[wr_ptr_q]    <= win_q;
    end
  end

  assign job_sample_o = f_sample_q[rd_ptr_q];
  assign job_full_o   = f_full_q[rd_ptr_q];
  assign job_base_o   = f_base_q[rd_ptr_q];
  assign job_wpos_o   = f_wpos_q[rd_ptr_q];
  assign job_window_o = f_win_q[rd_ptr_q];

endmodule

/* hdl/rhrr_back.sv */
// Back end: walks the window, accumulates range and squares, takes logs,
// divides and saturates. Depends on rhrr_pkg and rhrr_log.
`timescale 1ns / 1ps

module rhrr_back import rhrr_pkg::*; #(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  localparam int AW = $clog2(MAX_WINDOW),
  localparam int WW = $clog2(MAX_WINDOW + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                restart_i,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  logic [SAMPLE_W-1:0] job_sample_i,
  input  logic                job_full_i,
  input  logic [AW-1:0]       job_base_i,
  input  logic [AW-1:0]       job_wpos_i,
  input  logic [WW-1:0]       job_window_i,
  output logic                ram_we_o,
  output logic                ram_re_o,
  output logic [AW-1:0]       ram_addr_o,
  output logic [SAMPLE_W-1:0] ram_wdata_o,
  input  logic [SAMPLE_W-1:0] ram_rdata_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [HURST_W-1:0]  hurst_estimate_o,
  output logic                estimate_valid_o
);

  localparam int SW   = SAMPLE_W + WW;
  localparam int DW   = SW + 1;
  localparam int AD   = SW;
  localparam int H    = (AD + 1) / 2;
  localparam int HL   = AD - H;
  localparam int P00W = 2 * H;
  localparam int P11W = 2 * HL;
  localparam int SQ   = 2 * AD;
  localparam int DDW  = SQ + WW;
  localparam int CW   = AD + WW + 1;
  localparam int LIN  = DDW;
  localparam int PW   = $clog2(LIN);
  localparam int LGW  = PW + FRAC_W;
  localparam int NUMW = LGW + 3;
  localparam int QW   = NUMW + Q_FRAC;
  localparam int DENW = LGW + 1;
  localparam int DCW  = $clog2(QW);

  localparam logic [AW-1:0]  LastPos = AW'(MAX_WINDOW - 1);
  localparam logic [DCW-1:0] LastDiv = DCW'(QW - 1);
  localparam logic [QW-1:0]  PosLim  = QW'(32767);
  localparam logic [QW-1:0]  NegLim  = QW'(32768);

  back_state_e state_q, state_d;

  logic [SAMPLE_W-1:0] x_q;
  logic                full_q;
  logic [AW-1:0]       wpos_q;
  logic [WW-1:0]       w_q;
  logic [AW-1:0]       addr_q;
  logic [WW-1:0]       k_q;
  logic [SW-1:0]       sum_q;
  logic [SAMPLE_W-1:0] old_q;
  logic                got_old_q;
  logic                vres_q;

  logic                rv_q, va_q, vb_q, vc_q, vd_q, ve_q;
  logic [SW-1:0]       wx_q;
  logic signed [DW-1:0] d_q;
  logic signed [CW-1:0] c_q, cmin_q, cmax_q;
  logic [AD-1:0]       ad_q;
  logic [P00W-1:0]     pp00_q;
  logic [AD-1:0]       pp01_q;
  logic [P11W-1:0]     pp11_q;
  logic [SQ-1:0]       sq_q;
  logic [DDW-1:0]      dacc_q;

  logic [LGW-1:0]      lr_q, ld_q;
  logic signed [NUMW-1:0] num_q;
  logic [DENW-1:0]     den_q;
  logic                neg_q;
  logic [QW-1:0]       quo_q;
  logic [DENW-1:0]     rem_q;
  logic [DCW-1:0]      dcnt_q;
  logic [HURST_W-1:0]  hurst_q;
  logic                est_q;

  logic                pipe_busy;
  logic [CW-1:0]       rng;
  logic                log_start;
  logic [LIN-1:0]      log_in;
  logic                log_done;
  logic [LGW-1:0]      log_res;
  logic signed [DW-1:0] d_nx;
  logic [NUMW-1:0]     mag;
  logic [DENW:0]       rem_sh;
  logic                ge;
  logic [HURST_W-1:0]  sat;

  assign pipe_busy = rv_q || va_q || vb_q || vc_q || vd_q || ve_q;
  assign rng       = CW'(cmax_q - cmin_q);
  assign d_nx      = $signed({1'b0, wx_q}) - $signed({1'b0, sum_q});
  assign mag       = num_q[NUMW-1] ? NUMW'(-num_q) : NUMW'(num_q);
  assign rem_sh    = {rem_q, quo_q[QW-1]};
  assign ge        = rem_sh >= {1'b0, den_q};

  always_comb begin
    if (!neg_q) begin
      sat = (quo_q > PosLim) ? HURST_MAX : quo_q[HURST_W-1:0];
    end else begin
      sat = (quo_q > NegLim) ? HURST_MIN : HURST_W'(~quo_q[HURST_W-1:0] + 1'b1);
    end
  end

  rhrr_log #(.IN_W(LIN)) u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .value_i (log_in),
    .done_o  (log_done),
    .log_o   (log_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    log_start = 1'b0;
    log_in    = LIN'(w_q);
    unique case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          state_d = job_full_i ? BK_WALK : BK_WRITE;
        end
      end
      BK_WALK: begin
        if (k_q == w_q - WW'(1)) begin
          state_d = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        log_in = LIN'(rng);
        if (!pipe_busy) begin
          if (dacc_q != '0) begin
            state_d   = BK_LOGR;
            log_start = 1'b1;
          end else begin
            state_d = BK_WRITE;
          end
        end
      end
      BK_LOGR: begin
        log_in = dacc_q;
        if (log_done) begin
          state_d   = BK_LOGD;
          log_start = 1'b1;
        end
      end
      BK_LOGD: begin
        if (log_done) begin
          state_d   = BK_LOGW;
          log_start = 1'b1;
        end
      end
      BK_LOGW: begin
        if (log_done) begin
          state_d = BK_DPREP;
        end
      end
      BK_DPREP: state_d = BK_DIV;
      BK_DIV: begin
        if (dcnt_q == LastDiv) begin
          state_d = BK_WRITE;
        end
      end
      BK_WRITE: state_d = BK_OUT;
      BK_OUT: begin
        if (out_ready_i) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign job_ready_o = state_q == BK_IDLE;
  assign ram_re_o    = state_q == BK_WALK;
  assign ram_we_o    = state_q == BK_WRITE;
  assign ram_addr_o  = (state_q == BK_WRITE) ? wpos_q : addr_q;
  assign ram_wdata_o = x_q;

  // Stage valids and the running window sum are control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q  <= 1'b0;
      va_q  <= 1'b0;
      vb_q  <= 1'b0;
      vc_q  <= 1'b0;
      vd_q  <= 1'b0;
      ve_q  <= 1'b0;
      sum_q <= '0;
    end else begin
      rv_q <= state_q == BK_WALK;
      va_q <= rv_q;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
      if (restart_i) begin
        sum_q <= '0;
      end else if (state_q == BK_WRITE) begin
        sum_q <= sum_q - (full_q ? SW'(old_q) : '0) + SW'(x_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BK_IDLE && job_valid_i) begin
      x_q       <= job_sample_i;
      full_q    <= job_full_i;
      wpos_q    <= job_wpos_i;
      w_q       <= job_window_i;
      addr_q    <= job_base_i;
      k_q       <= '0;
      c_q       <= '0;
      cmin_q    <= '0;
      cmax_q    <= '0;
      dacc_q    <= '0;
      got_old_q <= 1'b0;
      vres_q    <= 1'b0;
    end
    if (state_q == BK_WALK) begin
      k_q    <= k_q + WW'(1);
      addr_q <= (addr_q == LastPos) ? '0 : addr_q + AW'(1);
    end
    if (rv_q) begin
      wx_q <= SW'(w_q) * SW'(ram_rdata_i);
      if (!got_old_q) begin
        old_q     <= ram_rdata_i;
        got_old_q <= 1'b1;
      end
    end
    if (va_q) begin
      d_q <= d_nx;
    end
    if (vb_q) begin
      c_q  <= c_q + CW'(d_q);
      ad_q <= d_q[DW-1] ? AD'(-d_q) : AD'(d_q);
    end
    if (vc_q) begin
      // The last cumulative deviation is always zero, so zero seeds min and max.
      if (c_q < cmin_q) begin
        cmin_q <= c_q;
      end
      if (c_q > cmax_q) begin
        cmax_q <= c_q;
      end
      pp00_q <= P00W'(ad_q[H-1:0]) * P00W'(ad_q[H-1:0]);
      pp01_q <= AD'(ad_q[AD-1:H]) * AD'(ad_q[H-1:0]);
      pp11_q <= P11W'(ad_q[AD-1:H]) * P11W'(ad_q[AD-1:H]);
    end
    if (vd_q) begin
      sq_q <= (SQ'(pp11_q) << (2 * H)) + (SQ'(pp01_q) << (H + 1)) + SQ'(pp00_q);
    end
    if (ve_q) begin
      dacc_q <= dacc_q + DDW'(sq_q);
    end
    if (state_q == BK_DRAIN && !pipe_busy) begin
      vres_q <= dacc_q != '0;
    end
    if (state_q == BK_LOGR && log_done) begin
      lr_q <= log_res;
    end
    if (state_q == BK_LOGD && log_done) begin
      ld_q <= log_res;
    end
    if (state_q == BK_LOGW && log_done) begin
      num_q <= $signed(NUMW'({lr_q, 1'b0})) - $signed(NUMW'(ld_q))
             + $signed(NUMW'(log_res));
      den_q <= {log_res, 1'b0};
    end
    if (state_q == BK_DPREP) begin
      neg_q  <= num_q[NUMW-1];
      quo_q  <= QW'({mag, {Q_FRAC{1'b0}}}) + QW'(den_q[DENW-1:1]);
      rem_q  <= '0;
      dcnt_q <= '0;
    end
    if (state_q == BK_DIV) begin
      rem_q  <= ge ? DENW'(rem_sh - {1'b0, den_q}) : rem_sh[DENW-1:0];
      quo_q  <= {quo_q[QW-2:0], ge};
      dcnt_q <= dcnt_q + DCW'(1);
    end
    if (state_q == BK_WRITE) begin
      hurst_q <= vres_q ? sat : '0;
      est_q   <= vres_q;
    end
  end

  assign out_valid_o      = state_q == BK_OUT;
  assign hurst_estimate_o = hurst_q;
  assign estimate_valid_o = est_q;

endmodule

/* hdl/rolling_hurst_rescaled_range_core.sv */
// Top level of the rolling rescaled-range Hurst estimator.
// Depends on rhrr_pkg, rhrr_ram, rhrr_front and rhrr_back.
//
// Usage: every input beat on in_valid_i/in_ready_o carries one unsigned
// sample, and each causes exactly one output beat on out_valid_o/out_ready_i
// with hurst_estimate_o (signed Q3.12) and estimate_valid_o. The estimate is
// taken over the window of samples that came before the current one.
// The window length is written through cfg_valid_i/window_length_i; a write
// clamps the value to [4, MAX_WINDOW] and restarts filling. Write it only
// while the block is idle.
// While the window is not yet full a beat goes straight to the history write
// and the result. With a full window of W samples the back end walks the
// history one sample per cycle (one RAM read port), drains its pipeline,
// makes three runs of the shared log unit and then runs a bit-serial divider.
// The single back-end sequencer finishes one beat before it takes the next.
// Reset clears the fill count, write position and running sum, and sets the
// window to 256 (or MAX_WINDOW if smaller); the history needs no clearing.
// A stalled receiver holds the result register; the front end still takes
// up to two beats into its queue before in_ready_o drops.
`timescale 1ns / 1ps

module rolling_hurst_rescaled_range_core import rhrr_pkg::*; #(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFG_W-1:0]    window_length_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SAMPLE_W-1:0] sample_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [HURST_W-1:0]  hurst_estimate_o,
  output logic                estimate_valid_o
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int WW = $clog2(MAX_WINDOW + 1);

  // Job handoff between the front queue and the back sequencer.
  logic                restart;
  logic                job_valid, job_ready;
  logic [SAMPLE_W-1:0] job_sample;
  logic                job_full;
  logic [AW-1:0]       job_base, job_wpos;
  logic [WW-1:0]       job_window;

  // History RAM port, owned by the back end.
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_addr;
  logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;

  rhrr_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .window_length_i (window_length_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sample_value_i  (sample_value_i),
    .restart_o       (restart),
    .job_valid_o     (job_valid),
    .job_ready_i     (job_ready),
    .job_sample_o    (job_sample),
    .job_full_o      (job_full),
    .job_base_o      (job_base),
    .job_wpos_o      (job_wpos),
    .job_window_o    (job_window)
  );

  rhrr_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WINDOW)) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  rhrr_back #(.MAX_WINDOW(MAX_WINDOW)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .restart_i        (restart),
    .job_valid_i      (job_valid),
    .job_ready_o      (job_ready),
    .job_sample_i     (job_sample),
    .job_full_i       (job_full),
    .job_base_i       (job_base),
    .job_wpos_i       (job_wpos),
    .job_window_i     (job_window),
    .ram_we_o         (ram_we),
    .ram_re_o         (ram_re),
    .ram_addr_o       (ram_addr),
    .ram_wdata_o      (ram_wdata),
    .ram_rdata_i      (ram_rdata),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .hurst_estimate_o (hurst_estimate_o),
    .estimate_valid_o (estimate_valid_o)
  );

  // An invalid estimate always reads as zero.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !estimate_valid_o |-> hurst_estimate_o == '0)
    else $error("invalid estimate is not zero");

  // The history RAM is never read and written in the same cycle.
  a_ram_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("history RAM read and write collide");

  // The back end takes no new job while a result waits.
  a_hold_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !job_ready)
    else $error("job taken while a result is pending");

  // A history write is always followed by the result beat.
  a_write_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> out_valid_o)
    else $error("result did not follow history write");

endmodule

/* bench/rolling_hurst_rescaled_range_core_test.sv */
// Self-checking testbench for the rolling rescaled-range Hurst estimator.
// Depends on rhrr_pkg and rolling_hurst_rescaled_range_core; needs no files.
`timescale 1ns / 1ps

module rolling_hurst_rescaled_range_core_test import rhrr_pkg::*;;

  localparam int HIST_DEPTH = DEF_MAX_WINDOW;

  logic                clk;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_W-1:0]    window_length;
  logic                in_valid;
  logic                in_ready;
  logic [SAMPLE_W-1:0] sample_value;
  logic                out_valid;
  logic                out_ready;
  logic [HURST_W-1:0]  hurst_estimate;
  logic                estimate_valid;

  rolling_hurst_rescaled_range_core i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .window_length_i (window_length),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .sample_value_i  (sample_value),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .hurst_estimate_o(hurst_estimate),
    .estimate_valid_o(estimate_valid)
  );

  // One estimate waiting to come out of the block.
  typedef struct {
    logic [HURST_W-1:0] hurst;
    logic               ok;
  } estimate_t;

  estimate_t pending_estimates[$];
  int        mismatches = 0;

  // Private copy of the estimator state, advanced on every accepted sample beat.
  logic [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];
  int unsigned         hist_wr;
  int unsigned         hist_fill;
  longint              hist_sum;
  int unsigned         win_reg;

  // When set, neither side inserts idle cycles, so back-to-back beats happen.
  bit no_idle = 0;

  // The directed part is a list of window writes and sample beats. Rows with
  // known_exp set carry the estimate that is obvious by inspection.
  typedef struct {
    bit                  is_cfg;
    logic [CFG_W-1:0]    win;
    logic [SAMPLE_W-1:0] smp;
    bit                  known_exp;
    logic [HURST_W-1:0]  hurst;
    logic                ok;
  } step_row_t;

  localparam int NUM_ROWS = 24;
  step_row_t dir_rows [NUM_ROWS] = '{
    // After reset the window is 256, so the first beats cannot be valid.
    '{0, 9'd0,   32'h0000_0000, 1, 16'h0000, 1'b0},
    '{0, 9'd0,   32'hffff_ffff, 1, 16'h0000, 1'b0},
    // A write of zero clamps up to the minimum window of four and restarts.
    '{1, 9'd0,   32'h0,         0, 16'h0000, 1'b0},
    '{0, 9'd0,   32'h0000_0007, 1, 16'h0000, 1'b0},
    '{0, 9'd0,   32'h0000_0007, 1, 16'h0000, 1'b0},
    '{0, 9'd0,   32'h0000_0007, 1, 16'h0000, 1'b0},
    '{0, 9'd0,   32'h0000_0007, 1, 16'h0000, 1'b0},
    // The window now holds four equal samples, so the deviation is zero.
    '{0, 9'd0,   32'h0000_0007, 1, 16'h0000, 1'b0},
    '{0, 9'd0,   32'hffff_ffff, 0, 16'h0000, 1'b0},
    '{0, 9'd0,   32'h0000_0000, 0, 16'h0000, 1'b0},
    '{0, 9'd0,   32'hffff_ffff, 0, 16'h0000, 1'b0},
    '{0, 9'd0,   32'h0000_0000, 0, 16'h0000, 1'b0},
    '{0, 9'd0,   32'h0000_0001, 0, 16'h0000, 1'b0},
    '{0, 9'd0,   32'h8000_0000, 0, 16'h0000, 1'b0},
    // Three is below the minimum and acts as four.
    '{1, 9'd3,   32'h0,         0, 16'h0000, 1'b0},
    '{0, 9'd0,   32'h0000_0000, 1, 16'h0000, 1'b0},
    '{0, 9'd0,   32'h0000_0000, 1, 16'h0000, 1'b0},
    '{0, 9'd0,   32'h0000_0000, 1, 16'h0000, 1'b0},
    '{0, 9'd0,   32'h0000_0000, 1, 16'h0000, 1'b0},
    '{0, 9'd0,   32'h0000_0000, 1, 16'h0000, 1'b0},
    '{0, 9'd0,   32'hffff_ffff, 0, 16'h0000, 1'b0},
    // The largest exact window; a restart leaves it unfilled.
    '{1, 9'd256, 32'h0,         0, 16'h0000, 1'b0},
    '{0, 9'd0,   32'h1234_5678, 1, 16'h0000, 1'b0},
    '{0, 9'd0,   32'hedcb_a987, 1, 16'h0000, 1'b0}
  };

  // Window settings and beat counts of the random phases. 511 clamps to 256
  // and gets enough beats to fill the window and go on past it.
  localparam int NUM_PHASES = 6;
  int phase_win  [NUM_PHASES] = '{5, 9, 4, 17, 64, 511};
  int phase_len  [NUM_PHASES] = '{30, 40, 30, 40, 60, 270};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Fixed-point log2 with 16 fraction bits: normalize to a 1.31 mantissa,
  // then square sixteen times and collect one fraction bit per square.
  function automatic longint log2_q16(input logic [127:0] v);
    int          p;
    logic [63:0] m;
    longint      frac;
    p = 0;
    frac = 0;
    if (v == '0) return 0;
    for (int i = 127; i >= 0; i--) begin
      if (v[i]) begin
        p = i;
        break;
      end
    end
    if (p >= 31) m = 64'(v >> (p - 31));
    else m = 64'(v << (31 - p));
    m = {32'h0, m[31:0]};
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return longint'(p) * 65536 + frac;
  endfunction

  function automatic void restart_window(input logic [CFG_W-1:0] win);
    win_reg   = win;
    hist_wr   = 0;
    hist_fill = 0;
    hist_sum  = 0;
  endfunction

  // Works out the estimate for one sample beat over the preceding window,
  // then slides the window to take the new sample in.
  function automatic estimate_t hurst_of_window(input logic [SAMPLE_W-1:0] x);
    estimate_t    e;
    int unsigned  w;
    int unsigned  base;
    longint       d, ad, c, cmin, cmax, lr, ld, lw, num, den, q, hq;
    logic [127:0] dsq;
    w = win_reg;
    if (w < WINDOW_MIN) w = WINDOW_MIN;
    if (w > HIST_DEPTH) w = HIST_DEPTH;
    base = (hist_wr + HIST_DEPTH - w) % HIST_DEPTH;
    e.hurst = '0;
    e.ok = 1'b0;
    if (hist_fill >= w) begin
      c = 0;
      cmin = 0;
      cmax = 0;
      dsq = '0;
      for (int k = 0; k < w; k++) begin
        d = longint'(w) * longint'({32'h0, hist_mem[(base + k) % HIST_DEPTH]}) - hist_sum;
        ad = (d < 0) ? -d : d;
        c = c + d;
        if (k == 0 || c < cmin) cmin = c;
        if (k == 0 || c > cmax) cmax = c;
        dsq = dsq + 128'(ad) * 128'(ad);
      end
      if (dsq != '0) begin
        lr  = log2_q16(128'(cmax - cmin));
        ld  = log2_q16(dsq);
        lw  = log2_q16(128'(w));
        num = 2 * lr - ld + lw;
        den = 2 * lw;
        q   = num * 4096;
        // Round to nearest with ties away from zero, then saturate.
        if (q >= 0) hq = (q + den / 2) / den;
        else hq = -((-q + den / 2) / den);
        if (hq > 32767) hq = 32767;
        if (hq < -32768) hq = -32768;
        e.hurst = hq[15:0];
        e.ok = 1'b1;
      end
    end
    if (hist_fill >= w) hist_sum = hist_sum - longint'({32'h0, hist_mem[base]});
    else hist_fill++;
    hist_mem[hist_wr] = x;
    hist_sum = hist_sum + longint'({32'h0, x});
    hist_wr = (hist_wr + 1) % HIST_DEPTH;
    return e;
  endfunction

  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 14);
  endfunction

  // Window writes only happen with the block idle: every estimate is back
  // and a short pause has let the back end settle.
  task automatic write_window(input logic [CFG_W-1:0] win);
    while (pending_estimates.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_valid     <= 1'b1;
    window_length <= win;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    restart_window(win);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Sends one sample beat. Called and returning at a falling edge; valid is
  // left high so that a following beat with no gap goes out back to back.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit known_exp,
                             input estimate_t typed);
    int        gap;
    estimate_t e;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    sample_value <= s;
    do @(posedge clk); while (!(in_valid && in_ready));
    e = hurst_of_window(s);
    if (known_exp) e = typed;
    pending_estimates.insert(pending_estimates.size(), e);
    @(negedge clk);
  endtask

  // The result side stalls for a freshly drawn number of cycles per beat.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Every result beat is compared with the oldest pending estimate.
  always @(posedge clk) begin
    estimate_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_estimates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: hurst %h valid %b", hurst_estimate,
                   estimate_valid);
      end else begin
        e = pending_estimates.pop_front();
        if (hurst_estimate !== e.hurst || estimate_valid !== e.ok) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected hurst %h valid %b, got hurst %h valid %b",
                     e.hurst, e.ok, hurst_estimate, estimate_valid);
        end
      end
    end
  end

  initial begin
    logic [SAMPLE_W-1:0] s;
    logic [SAMPLE_W-1:0] prev;
    estimate_t           typed;
    int                  kind;
    cfg_valid     = 1'b0;
    window_length = '0;
    in_valid      = 1'b0;
    sample_value  = '0;
    rst_n         = 1'b0;
    for (int i = 0; i < HIST_DEPTH; i++) hist_mem[i] = '0;
    restart_window(9'(WINDOW_RESET));
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed rows.
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (dir_rows[r].is_cfg) begin
        in_valid <= 1'b0;
        @(negedge clk);
        write_window(dir_rows[r].win);
      end else begin
        typed.hurst = dir_rows[r].hurst;
        typed.ok = dir_rows[r].ok;
        send_sample(dir_rows[r].smp, dir_rows[r].known_exp, typed);
      end
    end

    // Random phases. Most samples are random words or small-spread values
    // around a base, with runs of repeats, extremes and a random walk mixed
    // in, so both constant and strongly trending windows show up.
    prev = $urandom;
    typed.hurst = '0;
    typed.ok = 1'b0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      in_valid <= 1'b0;
      @(negedge clk);
      write_window(9'(phase_win[ph]));
      no_idle = (ph % 3 == 2);
      for (int n = 0; n < phase_len[ph]; n++) begin
        kind = $urandom_range(0, 99);
        if (kind < 35) s = $urandom;
        else if (kind < 60) s = 32'h4000_0000 + $urandom_range(0, 15);
        else if (kind < 72) s = prev;
        else if (kind < 80) s = ($urandom_range(0, 1) != 0) ? 32'hffff_ffff : 32'h0;
        else s = prev + $urandom_range(0, 1000) - 400;
        prev = s;
        send_sample(s, 1'b0, typed);
      end
    end
    in_valid <= 1'b0;
    no_idle = 0;

    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (mismatches == 0 && pending_estimates.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/rhrr_pkg.sv
hdl/rhrr_ram.sv
hdl/rhrr_log.sv
hdl/rhrr_front.sv
hdl/rhrr_back.sv
hdl/rolling_hurst_rescaled_range_core.sv
bench/rolling_hurst_rescaled_range_core_test.sv
